### rtl/iir4df_pkg.sv
// Types, constants and the control program of the order-4 direct-form IIR filter.
package iir4df_pkg;

  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned COEFF_WIDTH  = 24;
  localparam int unsigned GAIN_WIDTH   = 32;
  localparam int unsigned PAIR_WIDTH   = 2 * COEFF_WIDTH;
  localparam int unsigned HIST_DEPTH   = 4;
  localparam int unsigned NUM_REGS     = 6;
  localparam int unsigned IDX_WIDTH    = 3;
  localparam int unsigned ACC_SHIFT    = 36;
  localparam int unsigned MUL_WIDTH    = 33;
  localparam int unsigned PROD_WIDTH   = 64;
  localparam int unsigned ACC_WIDTH    = 65;
  localparam int unsigned RES_WIDTH    = PROD_WIDTH - (ACC_SHIFT - 32);
  localparam int unsigned PC_WIDTH     = 4;

  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(65536);
  localparam logic [ACC_WIDTH-1:0]  RND_BIAS   = ACC_WIDTH'(1) << (ACC_SHIFT - 1);
  localparam logic [SAMPLE_WIDTH-1:0] SAT_POS  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAT_NEG  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [IDX_WIDTH-1:0] REG_A0_A1 = IDX_WIDTH'(0);
  localparam logic [IDX_WIDTH-1:0] REG_A2_A3 = IDX_WIDTH'(1);
  localparam logic [IDX_WIDTH-1:0] REG_A4_B1 = IDX_WIDTH'(2);
  localparam logic [IDX_WIDTH-1:0] REG_B2_B3 = IDX_WIDTH'(3);
  localparam logic [IDX_WIDTH-1:0] REG_B4    = IDX_WIDTH'(4);
  localparam logic [IDX_WIDTH-1:0] REG_GAIN  = IDX_WIDTH'(5);

  localparam logic [PC_WIDTH-1:0] PC_IDLE   = PC_WIDTH'(0);
  localparam logic [PC_WIDTH-1:0] PC_FIRST  = PC_WIDTH'(1);
  localparam logic [PC_WIDTH-1:0] PC_ABS    = PC_WIDTH'(11);
  localparam logic [PC_WIDTH-1:0] PC_FIN    = PC_WIDTH'(14);
  localparam logic [PC_WIDTH-1:0] PC_PRESET = PC_WIDTH'(15);

  typedef enum logic [3:0] {
    A_NONE, A_X_IN, A_XH0, A_XH1, A_XH2, A_XH3,
    A_YH0, A_YH1, A_YH2, A_YH3, A_MAG_LO, A_MAG_HI
  } a_sel_e;

  typedef enum logic [3:0] {
    B_NONE, B_A0, B_A1, B_A2, B_A3, B_A4, B_B1, B_B2, B_B3, B_B4, B_GAIN
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ABS, ACC_RND
  } acc_op_e;

  typedef enum logic [1:0] {
    COND_NEVER, COND_NO_BEAT, COND_PRESET, COND_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    FIN_NONE, FIN_FILTER, FIN_PRESET
  } fin_e;

  typedef struct packed {
    a_sel_e                a_sel;
    b_sel_e                b_sel;
    acc_op_e               acc_op;
    cond_e                 cond;
    logic [PC_WIDTH-1:0]   target;
    logic                  ret;
    fin_e                  fin;
  } ucode_t;

  localparam ucode_t UCODE_NOP = '{
    a_sel: A_NONE, b_sel: B_NONE, acc_op: ACC_HOLD, cond: COND_NEVER,
    target: PC_IDLE, ret: 1'b0, fin: FIN_NONE
  };

  function automatic ucode_t ucode_rom(input logic [PC_WIDTH-1:0] pc);
    ucode_t uw;
    uw = UCODE_NOP;
    case (pc)
      PC_WIDTH'(0): begin
        uw.cond = COND_NO_BEAT;
        uw.target = PC_IDLE;
      end
      PC_WIDTH'(1): begin
        uw.a_sel = A_X_IN; uw.b_sel = B_A0;
        uw.cond = COND_PRESET; uw.target = PC_PRESET;
      end
      PC_WIDTH'(2): begin
        uw.a_sel = A_XH0; uw.b_sel = B_A1; uw.acc_op = ACC_LOAD;
      end
      PC_WIDTH'(3): begin
        uw.a_sel = A_XH1; uw.b_sel = B_A2; uw.acc_op = ACC_ADD;
      end
      PC_WIDTH'(4): begin
        uw.a_sel = A_XH2; uw.b_sel = B_A3; uw.acc_op = ACC_ADD;
      end
      PC_WIDTH'(5): begin
        uw.a_sel = A_XH3; uw.b_sel = B_A4; uw.acc_op = ACC_ADD;
      end
      PC_WIDTH'(6): begin
        uw.a_sel = A_YH0; uw.b_sel = B_B1; uw.acc_op = ACC_ADD;
      end
      PC_WIDTH'(7): begin
        uw.a_sel = A_YH1; uw.b_sel = B_B2; uw.acc_op = ACC_SUB;
      end
      PC_WIDTH'(8): begin
        uw.a_sel = A_YH2; uw.b_sel = B_B3; uw.acc_op = ACC_SUB;
      end
      PC_WIDTH'(9): begin
        uw.a_sel = A_YH3; uw.b_sel = B_B4; uw.acc_op = ACC_SUB;
      end
      PC_WIDTH'(10): begin
        uw.acc_op = ACC_SUB;
      end
      PC_WIDTH'(11): begin
        uw.acc_op = ACC_ABS;
      end
      PC_WIDTH'(12): begin
        uw.a_sel = A_MAG_LO; uw.b_sel = B_GAIN;
      end
      PC_WIDTH'(13): begin
        uw.a_sel = A_MAG_HI; uw.b_sel = B_GAIN; uw.acc_op = ACC_RND;
      end
      PC_WIDTH'(14): begin
        uw.cond = COND_OUT_BUSY; uw.target = PC_FIN;
        uw.ret = 1'b1; uw.fin = FIN_FILTER;
      end
      PC_WIDTH'(15): begin
        uw.cond = COND_OUT_BUSY; uw.target = PC_PRESET;
        uw.ret = 1'b1; uw.fin = FIN_PRESET;
      end
      default: begin
        uw = UCODE_NOP;
      end
    endcase
    return uw;
  endfunction

endpackage

### rtl/iir_order4_direct_form_filter_unit.sv
// Order-4 direct-form-I IIR filter in Q16.16 with Q4.20 taps, run by a microcoded sequencer.
// For a filter beat, a 4-bit step counter walks a 16-word control program that pushes nine tap
// products and two partial products of the gain scaling, one per cycle, through a single shared
// 33x33 signed multiplier and a 65-bit accumulator. A preset beat branches from the first step
// straight to the preset step. A new beat is taken only while the step counter sits at its idle
// step; the output register holds one result, so the next beat is accepted while that result
// waits, and the last step holds until the output register is free.
module iir_order4_direct_form_filter_unit
  import iir4df_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic [IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [PAIR_WIDTH-1:0]   cfg_data_i,

  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [31:0] sample
  input  logic                    s_axis_tuser,   // [0] kind

  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [SAMPLE_WIDTH-1:0] m_axis_tdata,   // [31:0] filtered
  output logic                    m_axis_tuser    // [0] saturated
);

  logic [PAIR_WIDTH-1:0]  reg_a01_q, reg_a23_q, reg_a4b1_q, reg_b23_q;
  logic [COEFF_WIDTH-1:0] reg_b4_q;
  logic [GAIN_WIDTH-1:0]  reg_gain_q;

  logic [PC_WIDTH-1:0]     pc_q, pc_d;
  ucode_t                  uw;
  logic                    cond_true;
  logic                    s_beat, m_beat, fin_fire;

  logic [SAMPLE_WIDTH-1:0] x_in_q;
  logic                    kind_q;
  logic [SAMPLE_WIDTH-1:0] xh_q [HIST_DEPTH];
  logic [SAMPLE_WIDTH-1:0] yh_q [HIST_DEPTH];

  logic signed [MUL_WIDTH-1:0]     mul_a, mul_b;
  logic signed [2*MUL_WIDTH-1:0]   mul_full;
  logic [PROD_WIDTH-1:0]           prod_q;
  logic [ACC_WIDTH-1:0]            acc_q, acc_d, prod_ext;
  logic [PROD_WIDTH-1:0]           mag_q;
  logic [GAIN_WIDTH-1:0]           gmag_q;
  logic                            neg_q;
  logic [ACC_WIDTH-1:0]            acc_neg;

  logic [PROD_WIDTH-1:0]   fin_sum;
  logic [RES_WIDTH-1:0]    res;
  logic                    res_zero, neg_eff, pos_over, neg_over, sat;
  logic [SAMPLE_WIDTH-1:0] mag_clip, y_val;

  logic                    m_valid_q;
  logic [SAMPLE_WIDTH-1:0] m_data_q;
  logic                    m_sat_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_a01_q  <= '0;
      reg_a23_q  <= '0;
      reg_a4b1_q <= '0;
      reg_b23_q  <= '0;
      reg_b4_q   <= '0;
      reg_gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A0_A1: reg_a01_q  <= cfg_data_i;
        REG_A2_A3: reg_a23_q  <= cfg_data_i;
        REG_A4_B1: reg_a4b1_q <= cfg_data_i;
        REG_B2_B3: reg_b23_q  <= cfg_data_i;
        REG_B4:    reg_b4_q   <= cfg_data_i[COEFF_WIDTH-1:0];
        REG_GAIN:  reg_gain_q <= cfg_data_i[GAIN_WIDTH-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer
  assign uw            = ucode_rom(pc_q);
  assign s_axis_tready = (pc_q == PC_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign m_beat        = m_valid_q && m_axis_tready;

  always_comb begin
    case (uw.cond)
      COND_NO_BEAT:  cond_true = !s_beat;
      COND_PRESET:   cond_true = kind_q;
      COND_OUT_BUSY: cond_true = m_valid_q && !m_axis_tready;
      default:       cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_d = uw.target;
    end else if (uw.ret) begin
      pc_d = PC_IDLE;
    end else begin
      pc_d = pc_q + PC_WIDTH'(1);
    end
  end

  assign fin_fire = (uw.fin != FIN_NONE) && !cond_true;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      x_in_q <= s_axis_tdata;
      kind_q <= s_axis_tuser;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (uw.a_sel)
      A_X_IN:   mul_a = MUL_WIDTH'(signed'(x_in_q));
      A_XH0:    mul_a = MUL_WIDTH'(signed'(xh_q[0]));
      A_XH1:    mul_a = MUL_WIDTH'(signed'(xh_q[1]));
      A_XH2:    mul_a = MUL_WIDTH'(signed'(xh_q[2]));
      A_XH3:    mul_a = MUL_WIDTH'(signed'(xh_q[3]));
      A_YH0:    mul_a = MUL_WIDTH'(signed'(yh_q[0]));
      A_YH1:    mul_a = MUL_WIDTH'(signed'(yh_q[1]));
      A_YH2:    mul_a = MUL_WIDTH'(signed'(yh_q[2]));
      A_YH3:    mul_a = MUL_WIDTH'(signed'(yh_q[3]));
      A_MAG_LO: mul_a = signed'({1'b0, mag_q[31:0]});
      A_MAG_HI: mul_a = signed'({1'b0, mag_q[63:32]});
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    case (uw.b_sel)
      B_A0:    mul_b = MUL_WIDTH'(signed'(reg_a01_q[PAIR_WIDTH-1:COEFF_WIDTH]));
      B_A1:    mul_b = MUL_WIDTH'(signed'(reg_a01_q[COEFF_WIDTH-1:0]));
      B_A2:    mul_b = MUL_WIDTH'(signed'(reg_a23_q[PAIR_WIDTH-1:COEFF_WIDTH]));
      B_A3:    mul_b = MUL_WIDTH'(signed'(reg_a23_q[COEFF_WIDTH-1:0]));
      B_A4:    mul_b = MUL_WIDTH'(signed'(reg_a4b1_q[PAIR_WIDTH-1:COEFF_WIDTH]));
      B_B1:    mul_b = MUL_WIDTH'(signed'(reg_a4b1_q[COEFF_WIDTH-1:0]));
      B_B2:    mul_b = MUL_WIDTH'(signed'(reg_b23_q[PAIR_WIDTH-1:COEFF_WIDTH]));
      B_B3:    mul_b = MUL_WIDTH'(signed'(reg_b23_q[COEFF_WIDTH-1:0]));
      B_B4:    mul_b = MUL_WIDTH'(signed'(reg_b4_q));
      B_GAIN:  mul_b = signed'({1'b0, gmag_q});
      default: mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (uw.a_sel != A_NONE) begin
      prod_q <= mul_full[PROD_WIDTH-1:0];
    end
  end

  // accumulator
  assign prod_ext = {prod_q[PROD_WIDTH-1], prod_q};
  assign acc_neg  = '0 - acc_q;

  always_comb begin
    case (uw.acc_op)
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      ACC_RND:  acc_d = {1'b0, prod_q} + RND_BIAS;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (uw.acc_op == ACC_ABS) begin
      mag_q  <= acc_q[ACC_WIDTH-1] ? acc_neg[PROD_WIDTH-1:0] : acc_q[PROD_WIDTH-1:0];
      gmag_q <= reg_gain_q[GAIN_WIDTH-1] ? (GAIN_WIDTH'(0) - reg_gain_q) : reg_gain_q;
      neg_q  <= acc_q[ACC_WIDTH-1] ^ reg_gain_q[GAIN_WIDTH-1];
    end
  end

  // rounding shift and saturation
  assign fin_sum  = prod_q + PROD_WIDTH'(acc_q[PROD_WIDTH-1:32]);
  assign res      = fin_sum[PROD_WIDTH-1:ACC_SHIFT-32];
  assign res_zero = (res == '0);
  assign neg_eff  = neg_q && !res_zero;
  assign pos_over = |res[RES_WIDTH-1:SAMPLE_WIDTH-1];
  assign neg_over = (|res[RES_WIDTH-1:SAMPLE_WIDTH])
                    || (res[SAMPLE_WIDTH-1] && (|res[SAMPLE_WIDTH-2:0]));
  assign sat      = neg_eff ? neg_over : pos_over;

  always_comb begin
    if (neg_eff) begin
      mag_clip = neg_over ? SAT_NEG : res[SAMPLE_WIDTH-1:0];
      y_val    = SAMPLE_WIDTH'(0) - mag_clip;
    end else begin
      mag_clip = pos_over ? SAT_POS : res[SAMPLE_WIDTH-1:0];
      y_val    = mag_clip;
    end
  end

  // history taps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else if (fin_fire) begin
      if (uw.fin == FIN_PRESET) begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
          xh_q[i] <= x_in_q;
          yh_q[i] <= x_in_q;
        end
      end else begin
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
          xh_q[i] <= xh_q[i-1];
          yh_q[i] <= yh_q[i-1];
        end
        xh_q[0] <= x_in_q;
        yh_q[0] <= y_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_beat) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      m_data_q <= (uw.fin == FIN_PRESET) ? x_in_q : y_val;
      m_sat_q  <= (uw.fin == FIN_PRESET) ? 1'b0 : sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

`ifndef SYNTH
  a_fin_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |-> !(m_valid_q && !m_axis_tready))
    else $error("result written while output register still full");

  a_beat_starts_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> (pc_q == PC_FIRST))
    else $error("accepted beat did not start the control program");

  a_preset_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && (uw.fin == FIN_PRESET)) |=> (m_data_q == $past(x_in_q)) && !m_sat_q)
    else $error("preset result does not echo the preset value");

  a_mag_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_ABS) |=> !mag_q[PROD_WIDTH-1])
    else $error("accumulator magnitude out of range");
`endif

endmodule
